FILE: src/dbr_pkg.sv
// Package for the button debounce core with press lockout.
// Holds the transaction payload types, the lane interface types and shared constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dbr_pkg;

	// Fixed field widths.
	localparam int unsigned BTN_W   = 4;
	localparam int unsigned TIME_W  = 48;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned GUARD_W = 16;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 16;

	// Saturation limits.
	localparam logic [COUNT_W-1:0] COUNT_CEIL = 8'hFF;
	localparam logic [TIME_W-1:0]  TIME_MAX   = {TIME_W{1'b1}};

	// Register reset values.
	localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 8'd4;
	localparam logic [GUARD_W-1:0] GUARD_RESET    = 16'd350;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_SAMPLES = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GUARD_MS         = 8'd1;

	// One input sample.
	typedef struct packed {
		logic [BTN_W-1:0]  raw_buttons;
		logic [TIME_W-1:0] now_ms;
		logic              consume_events;
	} sample_t;

	// One result.
	typedef struct packed {
		logic [BTN_W-1:0] stable_buttons;
		logic [BTN_W-1:0] new_presses;
		logic [BTN_W-1:0] pending_presses;
	} result_t;

	// Live configuration seen by every lane.
	typedef struct packed {
		logic [COUNT_W-1:0] debounce_samples;
		logic [GUARD_W-1:0] guard_ms;
	} cfg_t;

	// What one lane reports for the current sample.
	typedef struct packed {
		logic stable;
		logic rising;
	} lane_out_t;

endpackage

`default_nettype wire

FILE: src/dbr_lane.sv
// One button lane: change counter, debounced bit and press lockout deadline.
// Depends on dbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbr_lane (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire logic                          raw_on,
	input  wire logic [dbr_pkg::TIME_W-1:0]    now_ms,
	input  wire dbr_pkg::cfg_t                 cfg,
	output dbr_pkg::lane_out_t                 lane
);
	import dbr_pkg::*;

	logic                 held_q;
	logic [COUNT_W-1:0]   count_q;
	logic [TIME_W-1:0]    deadline_q;

	logic                 differ;
	logic [COUNT_W-1:0]   count_inc;
	logic                 flip;
	logic                 rise;
	logic [TIME_W:0]      deadline_sum;
	logic [TIME_W-1:0]    deadline_next;

	// Count differing samples, saturating, and flip once the threshold is met.
	// A threshold of zero flips on the first differing sample, as one does.
	always_comb begin
		differ    = raw_on ^ held_q;
		count_inc = (count_q == COUNT_CEIL) ? count_q : count_q + COUNT_W'(1);
		flip      = differ && !(count_inc < cfg.debounce_samples);
		rise      = flip && raw_on && (now_ms >= deadline_q);
	end

	// The next lockout deadline saturates at the top of the time range.
	always_comb begin
		deadline_sum  = {1'b0, now_ms} + {{(TIME_W + 1 - GUARD_W){1'b0}}, cfg.guard_ms};
		deadline_next = deadline_sum[TIME_W] ? TIME_MAX : deadline_sum[TIME_W-1:0];
	end

	assign lane.stable = held_q ^ flip;
	assign lane.rising = rise;

	// Lane state advances on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= 1'b0;
			count_q    <= '0;
			deadline_q <= '0;
		end else if (fire) begin
			held_q  <= held_q ^ flip;
			count_q <= (!differ || flip) ? '0 : count_inc;
			if (rise) begin
				deadline_q <= deadline_next;
			end
		end
	end

	a_rise_sets_stable: assert property (@(posedge clk) disable iff (!arst_n)
		lane.rising |-> lane.stable && !held_q)
		else $error("lane reports a press without a debounced rising edge");

	a_count_clears_on_flip: assert property (@(posedge clk) disable iff (!arst_n)
		fire && flip |=> count_q == '0)
		else $error("change count not cleared after a flip");

	a_deadline_moves_on_rise: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rise |=> deadline_q >= $past(now_ms))
		else $error("lockout deadline fell behind the accepted press time");

endmodule

`default_nettype wire

FILE: src/dbr_merge.sv
// Merging stage: collects lane results, keeps the pending press set and holds
// results in an output register with a skid entry. Depends on dbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbr_merge (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   fire,
	input  wire logic                                   consume,
	input  wire dbr_pkg::lane_out_t [dbr_pkg::BTN_W-1:0] lanes,
	output logic                                        accept_ok,
	output logic                                        result_valid,
	input  wire logic                                   result_ready,
	output dbr_pkg::result_t                            result
);
	import dbr_pkg::*;

	logic [BTN_W-1:0] pending_q;
	logic [BTN_W-1:0] stable_now;
	logic [BTN_W-1:0] rising_now;
	logic [BTN_W-1:0] pending_now;
	result_t          fresh;

	result_t          main_q;
	logic             main_valid_q;
	result_t          skid_q;
	logic             skid_valid_q;
	logic             out_fire;

	// Gather the lane bits into one result.
	always_comb begin
		for (int i = 0; i < BTN_W; i++) begin
			stable_now[i] = lanes[i].stable;
			rising_now[i] = lanes[i].rising;
		end
		pending_now          = pending_q | rising_now;
		fresh.stable_buttons  = stable_now;
		fresh.new_presses     = rising_now;
		fresh.pending_presses = pending_now;
	end

	// Pending presses are reported first and then cleared when consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (fire) begin
			pending_q <= consume ? '0 : pending_now;
		end
	end

	// Output register and one skid entry; input is taken while the skid is empty.
	assign out_fire     = main_valid_q && result_ready;
	assign accept_ok    = !skid_valid_q;
	assign result_valid = main_valid_q;
	assign result       = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				if (!main_valid_q || out_fire) begin
					main_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_fire) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (!main_valid_q || out_fire) begin
				main_q <= fresh;
			end else begin
				skid_q <= fresh;
			end
		end else if (out_fire && skid_valid_q) begin
			main_q <= skid_q;
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry holds a result while the output register is empty");

	a_new_in_pending: assert property (@(posedge clk) disable iff (!arst_n)
		main_valid_q |-> (main_q.new_presses & ~main_q.pending_presses) == '0)
		else $error("new press missing from the pending set");

	a_new_in_stable: assert property (@(posedge clk) disable iff (!arst_n)
		main_valid_q |-> (main_q.new_presses & ~main_q.stable_buttons) == '0)
		else $error("new press on a button that is not held");

	a_consume_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && consume |=> pending_q == '0)
		else $error("pending set survived a consuming transaction");

endmodule

`default_nettype wire

FILE: src/button_debounce_retrigger_guard_core.sv
// Top level of the button debounce core with press lockout: configuration
// registers, one lane per button and the merging stage. Depends on dbr_pkg,
// dbr_lane and dbr_merge.
// A result is registered in the output register, or in the skid entry while the
// output is stalled. Throughput: one sample per cycle while the skid entry is free.
// A two-entry output stage keeps input flowing while one result is stalled.
// Reset clears all button state, the pending set and the output stage, and
// loads the registers with 4 samples and 350 ms.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_retrigger_guard_core #(
	parameter int unsigned NUM_BUTTONS = 4
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               sample_valid,
	output logic                                    sample_ready,
	input  wire dbr_pkg::sample_t                   sample,
	output logic                                    result_valid,
	input  wire logic                               result_ready,
	output dbr_pkg::result_t                        result,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [dbr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [dbr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dbr_pkg::*;

	// Buttons past the field width are never sampled.
	localparam int unsigned LANES = (NUM_BUTTONS < BTN_W) ? NUM_BUTTONS : BTN_W;

	cfg_t                  cfg_q;
	logic                  fire;
	logic                  accept_ok;
	lane_out_t [BTN_W-1:0] lanes;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_samples <= DEBOUNCE_RESET;
			cfg_q.guard_ms         <= GUARD_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEBOUNCE_SAMPLES: cfg_q.debounce_samples <= cfg_data[COUNT_W-1:0];
				REG_GUARD_MS:         cfg_q.guard_ms         <= cfg_data[GUARD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign sample_ready = accept_ok;
	assign fire         = sample_valid && accept_ok;

	// One lane per sampled button; unused lanes report nothing.
	for (genvar g = 0; g < BTN_W; g++) begin : g_lane
		if (g < LANES) begin : g_on
			dbr_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.fire   (fire),
				.raw_on (sample.raw_buttons[g]),
				.now_ms (sample.now_ms),
				.cfg    (cfg_q),
				.lane   (lanes[g])
			);
		end else begin : g_off
			assign lanes[g] = '0;
		end
	end

	dbr_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.consume      (sample.consume_events),
		.lanes        (lanes),
		.accept_ok    (accept_ok),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

FILE: sim/tb_button_debounce_retrigger_guard_core.sv
// Self-checking testbench for button_debounce_retrigger_guard_core.
// A scoreboard class predicts each result from the accepted samples and the register settings.
// Depends on dbr_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_button_debounce_retrigger_guard_core;
	import dbr_pkg::*;

	// Tracks debounced state, lockout deadlines and pending presses, and keeps the results owed.
	class press_ledger;
		logic [BTN_W-1:0]   held;
		logic [COUNT_W-1:0] run_len [BTN_W];
		logic [TIME_W-1:0]  deadline [BTN_W];
		logic [BTN_W-1:0]   pending;
		logic [COUNT_W-1:0] threshold;
		logic [GUARD_W-1:0] guard;
		result_t            expected_results [$];
		int                 mismatches;
		int                 results_checked;
		int                 presses_seen;

		function new();
			held = '0;
			pending = '0;
			threshold = DEBOUNCE_RESET;
			guard = GUARD_RESET;
			mismatches = 0;
			results_checked = 0;
			presses_seen = 0;
			for (int b = 0; b < BTN_W; b++) begin
				run_len[b] = '0;
				deadline[b] = '0;
			end
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_DEBOUNCE_SAMPLES: begin
					threshold = data[COUNT_W-1:0];
				end
				REG_GUARD_MS: begin
					guard = data[GUARD_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// Works out the result that one accepted sample causes and queues it.
		function void predict_presses(sample_t s);
			logic [BTN_W-1:0] rising;
			logic [TIME_W:0]  next_deadline;
			result_t          r;
			rising = '0;
			for (int b = 0; b < BTN_W; b++) begin
				if (s.raw_buttons[b] == held[b]) begin
					run_len[b] = '0;
					continue;
				end
				if (run_len[b] != COUNT_CEIL)
					run_len[b] = run_len[b] + 1'b1;
				if (run_len[b] < threshold)
					continue;
				run_len[b] = '0;
				held[b] = s.raw_buttons[b];
				// A press counts only once the lockout has run out; the deadline saturates.
				if (s.raw_buttons[b] && s.now_ms >= deadline[b]) begin
					rising[b] = 1'b1;
					next_deadline = {1'b0, s.now_ms} + guard;
					deadline[b] = next_deadline[TIME_W] ? TIME_MAX : next_deadline[TIME_W-1:0];
				end
			end
			pending = pending | rising;
			r.stable_buttons = held;
			r.new_presses = rising;
			r.pending_presses = pending;
			expected_results.push_back(r);
			presses_seen += $countones(rising);
			if (s.consume_events)
				pending = '0;
		endfunction

		function void compare_field(string field, logic [BTN_W-1:0] want, logic [BTN_W-1:0] got);
			if (want !== got) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %h, actual %h", $realtime, field, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual %h", $realtime, got);
				return;
			end
			want = expected_results.pop_front();
			results_checked++;
			compare_field("stable_buttons", want.stable_buttons, got.stable_buttons);
			compare_field("new_presses", want.new_presses, got.new_presses);
			compare_field("pending_presses", want.pending_presses, got.pending_presses);
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  sample_valid;
	logic                  sample_ready;
	sample_t               sample;
	logic                  result_valid;
	logic                  result_ready;
	result_t               result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	press_ledger       ledger;
	int                send_idle_pct;
	int                recv_idle_pct;
	int                stall_left;
	int                samples_sent;
	int                settings_written;
	logic [BTN_W-1:0]  hold_pattern;
	int                hold_left;
	logic [TIME_W-1:0] clock_ms;

	button_debounce_retrigger_guard_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Offers one sample, idling at random first, and records it once accepted.
	task automatic send_sample(input logic [BTN_W-1:0] raw, input logic [TIME_W-1:0] now,
			input logic consume);
		sample_t s;
		s.raw_buttons = raw;
		s.now_ms = now;
		s.consume_events = consume;
		@(negedge clk);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (!sample_ready);
		ledger.predict_presses(s);
		samples_sent++;
	endtask

	// Waits until every owed result has arrived, then lets the pipeline settle.
	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		sample_valid <= 1'b0;
		while (ledger.outstanding() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		ledger.set_register(idx, data);
		settings_written++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Held button patterns around the threshold, with optional glitch samples mixed in.
	task automatic run_random(input int count, input int hold_min, input int hold_max,
			input int noise_pct, input int step_max);
		logic [BTN_W-1:0] raw;
		for (int n = 0; n < count; n++) begin
			if (hold_left == 0) begin
				hold_pattern = BTN_W'($urandom_range(15, 0));
				hold_left = $urandom_range(hold_max, hold_min);
			end
			hold_left--;
			raw = ($urandom_range(99, 0) < noise_pct) ? BTN_W'($urandom_range(15, 0)) : hold_pattern;
			clock_ms = clock_ms + TIME_W'($urandom_range(step_max, 0));
			send_sample(raw, clock_ms, $urandom_range(3, 0) == 0);
		end
	endtask

	// Result side: random back-pressure, or a long hold-off when one is requested.
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			ledger.check_result(result);
	end

	initial begin
		#5000000;
		$display("button_debounce_retrigger_guard_core verification failed");
		$finish;
	end

	initial begin
		ledger = new();
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		stall_left = 0;
		samples_sent = 0;
		settings_written = 0;
		hold_pattern = '0;
		hold_left = 0;
		clock_ms = '0;
		send_idle_pct = 9;
		recv_idle_pct = 84;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Threshold zero flips on the first differing sample; lockout, time going backwards
		// and consume behaviour under the reset guard time.
		write_register(REG_DEBOUNCE_SAMPLES, 16'd0);
		send_sample(4'h0, 48'd0, 1'b0);
		send_sample(4'hF, 48'd0, 1'b0);
		send_sample(4'h0, 48'd10, 1'b0);
		send_sample(4'hF, 48'd100, 1'b1);
		send_sample(4'h0, 48'h5555_5555_5555, 1'b0);
		send_sample(4'h0, 48'hAAAA_AAAA_AAAA, 1'b0);
		send_sample(4'h0, TIME_MAX, 1'b1);
		send_sample(4'hF, 48'd400, 1'b0);
		send_sample(4'h6, 48'd500, 1'b1);
		send_sample(4'hF, 48'd760, 1'b0);
		settle();

		// A matching sample in the middle of a run clears the count.
		write_register(REG_DEBOUNCE_SAMPLES, 16'd3);
		write_register(REG_GUARD_MS, 16'd0);
		send_sample(4'h0, 48'd800, 1'b0);
		send_sample(4'h0, 48'd800, 1'b0);
		send_sample(4'hF, 48'd801, 1'b0);
		send_sample(4'h0, 48'd802, 1'b0);
		send_sample(4'h0, 48'd803, 1'b0);
		send_sample(4'h0, 48'd804, 1'b0);
		send_sample(4'hA, 48'd804, 1'b0);
		send_sample(4'hA, 48'd804, 1'b1);
		send_sample(4'hA, 48'd805, 1'b0);
		settle();

		// Fast debounce, short guard; sender mostly busy, receiver mostly stalling.
		write_register(REG_DEBOUNCE_SAMPLES, 16'd1);
		write_register(REG_GUARD_MS, 16'd120);
		clock_ms = {16'h0, 32'($urandom_range(32'h7FFF_FFFF, 32'd1000))};
		hold_left = 0;
		run_random(200, 1, 5, 10, 30);
		settle();

		// Reset-like settings with the idling roles swapped.
		send_idle_pct = 84;
		recv_idle_pct = 9;
		write_register(REG_DEBOUNCE_SAMPLES, 16'd4);
		write_register(REG_GUARD_MS, 16'd350);
		hold_left = 0;
		run_random(200, 3, 8, 8, 80);
		settle();

		// Longest debounce and guard, clean holds so that a run can reach the threshold.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_register(REG_DEBOUNCE_SAMPLES, 16'd255);
		write_register(REG_GUARD_MS, 16'd65535);
		hold_left = 0;
		run_random(280, 254, 259, 0, 400);
		settle();

		// Long result stall while samples keep coming, then a full pause mid-phase.
		write_register(REG_DEBOUNCE_SAMPLES, 16'd7);
		write_register(REG_GUARD_MS, 16'd1000);
		hold_left = 0;
		run_random(40, 6, 11, 6, 150);
		stall_left = 60;
		run_random(60, 6, 11, 6, 150);
		settle();
		run_random(70, 6, 11, 6, 150);
		settle();

		// Deadline saturation near the top of the time range.
		write_register(REG_DEBOUNCE_SAMPLES, 16'd1);
		write_register(REG_GUARD_MS, 16'd65535);
		send_sample(4'h0, TIME_MAX - 48'd20, 1'b1);
		send_sample(4'h1, TIME_MAX - 48'd10, 1'b0);
		send_sample(4'h0, TIME_MAX - 48'd9, 1'b0);
		send_sample(4'h1, TIME_MAX - 48'd5, 1'b0);
		send_sample(4'h0, TIME_MAX - 48'd4, 1'b0);
		send_sample(4'h1, TIME_MAX, 1'b1);
		settle();

		if (ledger.outstanding() != 0) begin
			ledger.mismatches += ledger.outstanding();
			$display("%0t: %0d results never arrived, expected 0 outstanding, actual %0d",
				$realtime, ledger.outstanding(), ledger.outstanding());
		end
		$display("Drove %0d samples across %0d register writes; %0d results compared.",
			samples_sent, settings_written, ledger.results_checked);
		$display("The predicted results held %0d accepted presses in total.", ledger.presses_seen);
		if (ledger.mismatches == 0) begin
			$display("button_debounce_retrigger_guard_core verification clean");
		end else begin
			$display("button_debounce_retrigger_guard_core verification failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/dbr_pkg.sv
src/dbr_lane.sv
src/dbr_merge.sv
src/button_debounce_retrigger_guard_core.sv
sim/tb_button_debounce_retrigger_guard_core.sv
